### src/mpw_pkg.sv
package mpw_pkg;

    localparam int CPU_IDX_W   = 6;
    localparam int TICKS_W     = 64;
    localparam int COUNT_W     = 7;
    localparam int STRIKE_W    = 8;
    localparam int TALLY_W     = 7;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 1;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 24;

    localparam logic CMD_BASELINE = 1'b0;
    localparam logic CMD_CHECK    = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_CPU_COUNT    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIKE_LIMIT = 1'b1;

    localparam logic [COUNT_W-1:0]  CPU_COUNT_RESET    = 7'd1;
    localparam logic [STRIKE_W-1:0] STRIKE_LIMIT_RESET = 8'd3;
    localparam logic [STRIKE_W-1:0] STRIKE_MAX         = 8'd255;
    localparam logic [TALLY_W-1:0]  TALLY_MAX          = 7'd127;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_range;
    } t_ctrl_sts;

endpackage

### src/mpw_ram.sv
module mpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                 i_wr_data,
    input  logic                             i_rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/mpw_ctrl.sv
module mpw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    output logic               o_m_valid,
    input  logic               i_m_ready,
    input  mpw_pkg::t_ctrl_sts i_sts,
    output mpw_pkg::t_ctrl_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EVAL = 1'b1;

    logic r_state;
    logic n_state;
    logic r_m_valid;
    logic n_m_valid;
    mpw_pkg::t_ctrl_cmd w_cmd;

    always_comb begin
        n_state       = r_state;
        w_cmd.capture = 1'b0;
        w_cmd.commit  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid && i_sts.in_range) begin
                    w_cmd.capture = 1'b1;
                    n_state       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!r_m_valid || i_m_ready) begin
                    w_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_cmd.commit) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_m_valid;
    assign o_cmd     = w_cmd;

endmodule

### src/mpw_datapath.sv
module mpw_datapath #(
    parameter int MAX_CPUS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [mpw_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [mpw_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [mpw_pkg::S_TDATA_W-1:0]        i_s_tdata,
    input  logic                                 i_s_tuser,
    input  mpw_pkg::t_ctrl_cmd                   i_cmd,
    output mpw_pkg::t_ctrl_sts                   o_sts,
    output logic [mpw_pkg::M_TDATA_W-1:0]        o_m_tdata,
    output logic                                 o_m_tlast
);

    localparam int AW    = $clog2(MAX_CPUS > 1 ? MAX_CPUS : 2);
    localparam int RAM_W = mpw_pkg::TICKS_W + mpw_pkg::STRIKE_W;

    logic [mpw_pkg::COUNT_W-1:0]   r_cpu_count;
    logic [mpw_pkg::STRIKE_W-1:0]  r_strike_limit;
    logic [mpw_pkg::TALLY_W-1:0]   r_tally;
    logic [mpw_pkg::TALLY_W-1:0]   n_tally;
    logic                          r_cmd;
    logic [mpw_pkg::CPU_IDX_W-1:0] r_idx;
    logic [mpw_pkg::TICKS_W-1:0]   r_total;

    logic [mpw_pkg::CPU_IDX_W-1:0] r_out_id;
    logic                          r_out_stuck;
    logic [mpw_pkg::STRIKE_W-1:0]  r_out_strikes;
    logic                          r_out_done;
    logic [mpw_pkg::TALLY_W-1:0]   r_out_tally;
    logic                          r_out_dead;

    logic [mpw_pkg::COUNT_W-1:0]   w_eff_count;
    logic [mpw_pkg::CPU_IDX_W-1:0] w_in_idx;
    logic [mpw_pkg::TICKS_W-1:0]   w_in_busy;
    logic [mpw_pkg::TICKS_W-1:0]   w_in_idle;
    logic [RAM_W-1:0]              w_rd_data;
    logic [mpw_pkg::TICKS_W-1:0]   w_rd_total;
    logic [mpw_pkg::STRIKE_W-1:0]  w_rd_strikes;
    logic [mpw_pkg::STRIKE_W-1:0]  w_strikes;
    logic                          w_stuck;
    logic [mpw_pkg::TALLY_W-1:0]   w_tally;
    logic                          w_done;
    logic                          w_dead;

    assign w_in_idx  = i_s_tdata[5:0];
    assign w_in_busy = i_s_tdata[69:6];
    assign w_in_idle = i_s_tdata[133:70];

    assign w_eff_count = (32'(r_cpu_count) > MAX_CPUS) ? mpw_pkg::COUNT_W'(MAX_CPUS)
                                                       : r_cpu_count;
    assign o_sts.in_range = ({1'b0, w_in_idx} < w_eff_count);

    mpw_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_CPUS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.commit),
        .i_wr_addr (AW'(r_idx)),
        .i_wr_data ({r_total, w_strikes}),
        .i_rd_en   (i_cmd.capture),
        .i_rd_addr (AW'(w_in_idx)),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_total   = w_rd_data[RAM_W-1:mpw_pkg::STRIKE_W];
    assign w_rd_strikes = w_rd_data[mpw_pkg::STRIKE_W-1:0];

    always_comb begin
        w_strikes = '0;
        w_stuck   = 1'b0;
        w_tally   = r_tally;
        w_done    = 1'b0;
        w_dead    = 1'b0;
        n_tally   = r_tally;
        if (r_cmd == mpw_pkg::CMD_CHECK) begin
            if (r_total == w_rd_total) begin
                if (w_rd_strikes != mpw_pkg::STRIKE_MAX) begin
                    w_strikes = w_rd_strikes + 8'd1;
                end else begin
                    w_strikes = w_rd_strikes;
                end
            end
            w_stuck = (w_strikes >= r_strike_limit);
            if (w_stuck && (r_tally != mpw_pkg::TALLY_MAX)) begin
                w_tally = r_tally + 7'd1;
            end
            w_done  = ({1'b0, r_idx} == (w_eff_count - 7'd1));
            w_dead  = w_done && (w_tally >= w_eff_count);
            n_tally = w_done ? '0 : w_tally;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_count    <= mpw_pkg::CPU_COUNT_RESET;
            r_strike_limit <= mpw_pkg::STRIKE_LIMIT_RESET;
            r_tally        <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mpw_pkg::REG_CPU_COUNT:    r_cpu_count    <= i_cfg_data[6:0];
                    mpw_pkg::REG_STRIKE_LIMIT: r_strike_limit <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.commit) begin
                r_tally <= n_tally;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_s_tuser;
            r_idx   <= w_in_idx;
            r_total <= w_in_busy + w_in_idle;
        end
        if (i_cmd.commit) begin
            r_out_id      <= r_idx;
            r_out_stuck   <= w_stuck;
            r_out_strikes <= w_strikes;
            r_out_done    <= w_done;
            r_out_tally   <= w_tally;
            r_out_dead    <= w_dead;
        end
    end

    assign o_m_tdata = {1'b0, r_out_dead, r_out_tally, r_out_strikes, r_out_stuck, r_out_id};
    assign o_m_tlast = r_out_done;

endmodule

### src/multicore_progress_watchdog.sv
// Watches a set of CPUs for lack of progress. Each request on the slave stream
// carries one CPU's busy and idle tick readings; tuser selects a baseline sample
// or a periodic check. A check whose tick sum matches the stored total raises
// that CPU's strike count, and CPUs at the strike limit add to the round tally.
// The check for the last configured CPU ends the round and raises tlast, with
// deadlock set when the round's stuck tally reaches the CPU count.
// Each in-range request gives one result on the master stream; requests whose
// CPU index is at or beyond cpu_count give none.
// The configuration channel is always ready and sets cpu_count (index 0) and
// strike_limit (index 1); the user must write it only while the block is
// idle, which the block does not enforce. A request reads the per-CPU memory
// in the idle state and updates it in the evaluate state, which waits for a
// free output register; the next request is taken after that update. A result
// is valid in the cycle after its update and does not block the next read.
// Reset clears the tally and control state and restores the register defaults;
// the per-CPU memory is not cleared and must be loaded by baseline samples.
module multicore_progress_watchdog #(
    parameter int MAX_CPUS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mpw_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [mpw_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // cpu_index[5:0], busy_ticks[69:6], idle_ticks[133:70], zero fill.
    input  logic [mpw_pkg::S_TDATA_W-1:0]       i_s_axis_tdata,
    // cmd.
    input  logic                                i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // cpu_id[5:0], cpu_stuck[6], strikes_now[14:7], stuck_cpus[21:15],
    // deadlock[22], zero fill.
    output logic [mpw_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,
    output logic                                o_m_axis_tlast
);

    mpw_pkg::t_ctrl_cmd w_cmd;
    mpw_pkg::t_ctrl_sts w_sts;

    assign o_cfg_ready = 1'b1;

    mpw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    mpw_datapath #(
        .MAX_CPUS (MAX_CPUS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tlast   (o_m_axis_tlast)
    );

endmodule

### dv/tb_multicore_progress_watchdog.sv
module tb_multicore_progress_watchdog;

    localparam int NUM_CPUS = 64;
    localparam int TARGET_ITEMS = 850;
    localparam logic [mpw_pkg::TICKS_W-1:0] ONES = '1;

    typedef struct packed {
        logic                          cmd;
        logic [mpw_pkg::CPU_IDX_W-1:0] cpu;
        logic [mpw_pkg::TICKS_W-1:0]   busy;
        logic [mpw_pkg::TICKS_W-1:0]   idle;
    } t_probe;

    typedef struct packed {
        logic [mpw_pkg::CPU_IDX_W-1:0] cpu_id;
        logic                          stuck;
        logic [mpw_pkg::STRIKE_W-1:0]  strikes;
        logic                          round_end;
        logic [mpw_pkg::TALLY_W-1:0]   stuck_cpus;
        logic                          deadlock;
    } t_verdict;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [mpw_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [mpw_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [mpw_pkg::S_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic                            i_s_axis_tuser = 1'b0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [mpw_pkg::M_TDATA_W-1:0]   o_m_axis_tdata;
    logic                            o_m_axis_tlast;

    multicore_progress_watchdog #(
        .MAX_CPUS(NUM_CPUS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    // Predictor state.
    logic [mpw_pkg::TICKS_W-1:0]  stored_sum [NUM_CPUS];
    logic [mpw_pkg::STRIKE_W-1:0] strike_cnt [NUM_CPUS];
    logic [mpw_pkg::TALLY_W-1:0]  tally = '0;
    logic [mpw_pkg::COUNT_W-1:0]  cpus_reg = mpw_pkg::CPU_COUNT_RESET;
    logic [mpw_pkg::STRIKE_W-1:0] limit_reg = mpw_pkg::STRIKE_LIMIT_RESET;

    // Stimulus bookkeeping: which CPUs hold a baseline and the total they hold.
    bit                          primed [NUM_CPUS];
    logic [mpw_pkg::TICKS_W-1:0] shadow_sum [NUM_CPUS];
    int                          gen_items = 0;

    t_probe   probe_queue [$];
    t_verdict verdict_queue [$];
    t_probe   cur_probe;
    t_verdict want;
    int unsigned src_gap = 0;
    int unsigned snk_gap = 0;
    bit src_gaps_on = 1'b1;
    bit snk_gaps_on = 1'b1;
    int fails = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("FAIL multicore_progress_watchdog");
        $finish;
    end

    function automatic int unsigned active_cpus();
        return (cpus_reg > NUM_CPUS) ? NUM_CPUS : 32'(cpus_reg);
    endfunction

    function automatic logic [mpw_pkg::TICKS_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void predict_verdict(t_probe p);
        t_verdict v;
        logic [mpw_pkg::TICKS_W-1:0] sum;
        int unsigned n;
        n = active_cpus();
        if (p.cpu >= n) return;
        sum = p.busy + p.idle;
        v = '0;
        v.cpu_id = p.cpu;
        if (p.cmd == mpw_pkg::CMD_BASELINE) begin
            stored_sum[p.cpu] = sum;
            strike_cnt[p.cpu] = '0;
        end else begin
            if (sum == stored_sum[p.cpu]) begin
                if (strike_cnt[p.cpu] != mpw_pkg::STRIKE_MAX) strike_cnt[p.cpu]++;
            end else begin
                strike_cnt[p.cpu] = '0;
                stored_sum[p.cpu] = sum;
            end
            if (strike_cnt[p.cpu] >= limit_reg) begin
                v.stuck = 1'b1;
                if (tally != mpw_pkg::TALLY_MAX) tally++;
            end
        end
        v.strikes = strike_cnt[p.cpu];
        v.stuck_cpus = tally;
        if (p.cmd == mpw_pkg::CMD_CHECK && p.cpu == n - 1) begin
            v.round_end = 1'b1;
            v.deadlock = (tally >= n);
            tally = '0;
        end
        verdict_queue.push_back(v);
    endfunction

    function automatic void queue_probe(logic cmd, logic [mpw_pkg::CPU_IDX_W-1:0] cpu,
                                        logic [mpw_pkg::TICKS_W-1:0] busy,
                                        logic [mpw_pkg::TICKS_W-1:0] idle);
        t_probe p;
        p.cmd = cmd;
        p.cpu = cpu;
        p.busy = busy;
        p.idle = idle;
        probe_queue.push_back(p);
        if (cpu < active_cpus()) begin
            gen_items++;
            shadow_sum[cpu] = busy + idle;
            if (cmd == mpw_pkg::CMD_BASELINE) primed[cpu] = 1'b1;
        end
    endfunction

    function automatic void queue_total(logic cmd, logic [mpw_pkg::CPU_IDX_W-1:0] cpu,
                                        logic [mpw_pkg::TICKS_W-1:0] sum);
        logic [mpw_pkg::TICKS_W-1:0] busy;
        case ($urandom_range(0, 7))
            0: busy = '0;
            1: busy = ONES;
            default: busy = rand64();
        endcase
        queue_probe(cmd, cpu, busy, sum - busy);
    endfunction

    function automatic void queue_check(logic [mpw_pkg::CPU_IDX_W-1:0] cpu);
        if ($urandom_range(0, 3) != 0) queue_total(mpw_pkg::CMD_CHECK, cpu, shadow_sum[cpu]);
        else queue_total(mpw_pkg::CMD_CHECK, cpu, rand64());
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
            fails++;
        end
    endtask

    task automatic write_reg(input logic [mpw_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [mpw_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == mpw_pkg::REG_CPU_COUNT) cpus_reg = data[mpw_pkg::COUNT_W-1:0];
        else limit_reg = data;
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every request is taken and answered, then lets the pipeline drain.
    task automatic settle();
        do @(negedge i_clk);
        while (probe_queue.size() != 0 || i_s_axis_tvalid || verdict_queue.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_rounds();
        int unsigned n;
        int unsigned rounds;
        logic [mpw_pkg::CFG_DATA_W-1:0] cnt_val;
        logic [mpw_pkg::CFG_DATA_W-1:0] lim_val;
        case ($urandom_range(0, 7))
            0: cnt_val = 8'd1;
            1: cnt_val = 8'd64;
            2, 3: cnt_val = 8'($urandom_range(2, 8));
            4: cnt_val = 8'($urandom_range(1, 64));
            5: cnt_val = 8'($urandom_range(65, 255));
            default: cnt_val = 8'($urandom_range(2, 16));
        endcase
        case ($urandom_range(0, 7))
            0: lim_val = 8'd1;
            1: lim_val = 8'd255;
            2: lim_val = 8'd0;
            default: lim_val = 8'($urandom_range(1, 5));
        endcase
        write_reg(mpw_pkg::REG_CPU_COUNT, cnt_val);
        write_reg(mpw_pkg::REG_STRIKE_LIMIT, lim_val);
        @(negedge i_clk);
        src_gaps_on = ($urandom_range(0, 3) != 0);
        snk_gaps_on = ($urandom_range(0, 3) != 0);
        n = active_cpus();
        if (n == 0) begin
            repeat (4) queue_probe(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                                   rand64(), rand64());
        end else begin
            for (int c = 0; c < n; c++) begin
                if (!primed[c] || $urandom_range(0, 3) == 0)
                    queue_total(mpw_pkg::CMD_BASELINE, 6'(c), rand64());
            end
            rounds = (n > 16) ? $urandom_range(1, 2) : $urandom_range(2, 6);
            for (int r = 0; r < rounds; r++) begin
                for (int c = 0; c < n; c++) begin
                    case ($urandom_range(0, 19))
                        0: if (n < NUM_CPUS)
                            queue_probe(1'($urandom_range(0, 1)), 6'($urandom_range(n, 63)),
                                        rand64(), rand64());
                        1: continue;
                        2: queue_total(mpw_pkg::CMD_BASELINE, 6'(c), rand64());
                        3: queue_check(6'(c));
                        default: ;
                    endcase
                    queue_check(6'(c));
                end
            end
        end
        settle();
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata <= '0;
            i_s_axis_tuser <= 1'b0;
            src_gap = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) predict_verdict(cur_probe);
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (probe_queue.size() != 0) begin
                    cur_probe = probe_queue.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= {2'b00, cur_probe.idle, cur_probe.busy, cur_probe.cpu};
                    i_s_axis_tuser <= cur_probe.cmd;
                    src_gap = src_gaps_on ? $urandom_range(0, 15) : 0;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (verdict_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h", $time,
                             o_m_axis_tdata);
                    fails++;
                end else begin
                    want = verdict_queue.pop_front();
                    check_field("cpu_id", 64'(want.cpu_id), 64'(o_m_axis_tdata[5:0]));
                    check_field("cpu_stuck", 64'(want.stuck), 64'(o_m_axis_tdata[6]));
                    check_field("strikes_now", 64'(want.strikes), 64'(o_m_axis_tdata[14:7]));
                    check_field("stuck_cpus", 64'(want.stuck_cpus),
                                64'(o_m_axis_tdata[21:15]));
                    check_field("deadlock", 64'(want.deadlock), 64'(o_m_axis_tdata[22]));
                    check_field("round_done", 64'(want.round_end), 64'(o_m_axis_tlast));
                end
                snk_gap = snk_gaps_on ? $urandom_range(0, 15) : 0;
            end
            if (snk_gap != 0) begin
                snk_gap--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // One CPU at the reset settings: wrapping sums, strikes up to the limit and a change.
        queue_probe(mpw_pkg::CMD_BASELINE, 6'd0, ONES, ONES);
        repeat (4) queue_probe(mpw_pkg::CMD_CHECK, 6'd0, '0, ONES - 64'd1);
        queue_probe(mpw_pkg::CMD_CHECK, 6'd0, ONES, '0);
        queue_probe(mpw_pkg::CMD_CHECK, 6'd63, ONES, ONES);
        queue_probe(mpw_pkg::CMD_BASELINE, 6'd1, ONES, ONES);
        settle();

        // A CPU count of zero ignores everything.
        write_reg(mpw_pkg::REG_CPU_COUNT, 8'd0);
        write_reg(mpw_pkg::REG_STRIKE_LIMIT, 8'd0);
        @(negedge i_clk);
        queue_probe(mpw_pkg::CMD_CHECK, 6'd0, ONES, '0);
        queue_probe(mpw_pkg::CMD_BASELINE, 6'd0, '0, '0);
        settle();

        // An oversized count is clipped to the full set; a zero limit marks every check stuck.
        write_reg(mpw_pkg::REG_CPU_COUNT, 8'hFF);
        @(negedge i_clk);
        queue_probe(mpw_pkg::CMD_BASELINE, 6'd63, '0, '0);
        queue_probe(mpw_pkg::CMD_CHECK, 6'd63, '0, '0);
        queue_probe(mpw_pkg::CMD_BASELINE, 6'd0, rand64(), rand64());
        queue_probe(mpw_pkg::CMD_CHECK, 6'd0, rand64(), rand64());
        queue_probe(mpw_pkg::CMD_CHECK, 6'd63, ONES, ONES);
        settle();

        write_reg(mpw_pkg::REG_CPU_COUNT, 8'd2);
        write_reg(mpw_pkg::REG_STRIKE_LIMIT, 8'd255);
        @(negedge i_clk);
        queue_total(mpw_pkg::CMD_CHECK, 6'd0, shadow_sum[0]);
        queue_total(mpw_pkg::CMD_BASELINE, 6'd1, rand64());
        queue_total(mpw_pkg::CMD_CHECK, 6'd1, shadow_sum[1]);
        settle();

        // One CPU checked over and over within a round saturates its strikes and the tally.
        write_reg(mpw_pkg::REG_CPU_COUNT, 8'd64);
        write_reg(mpw_pkg::REG_STRIKE_LIMIT, 8'd1);
        @(negedge i_clk);
        k = $urandom_range(0, 62);
        queue_total(mpw_pkg::CMD_BASELINE, 6'(k), rand64());
        repeat (260) queue_total(mpw_pkg::CMD_CHECK, 6'(k), shadow_sum[k]);
        queue_total(mpw_pkg::CMD_BASELINE, 6'd63, rand64());
        queue_total(mpw_pkg::CMD_CHECK, 6'd63, shadow_sum[63]);
        settle();

        while (gen_items < TARGET_ITEMS) run_rounds();

        if (fails == 0) begin
            $display("PASS multicore_progress_watchdog");
        end else begin
            $display("FAIL multicore_progress_watchdog");
        end
        $finish;
    end

endmodule

### filelist.f
src/mpw_pkg.sv
src/mpw_ram.sv
src/mpw_ctrl.sv
src/mpw_datapath.sv
src/multicore_progress_watchdog.sv
dv/tb_multicore_progress_watchdog.sv
